FILE: rtl/hmtn_pkg.sv
// Shared types and constants for the heightmap triangle normal generator.
`default_nettype none

package hmtn_pkg;

	// Default sizes of the row store and the row counter.
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int MAX_ROWS_DEF  = 4096;

	// Configuration port geometry and register indexes.
	localparam int CFG_AW = 4;
	localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT  = 2'd1;
	localparam logic [1:0] REG_CELL_SPACING = 2'd2;

	// Datapath widths of the normalization units.
	localparam int SQ_W   = 32;
	localparam int SUM_W  = 34;
	localparam int QUO_W  = 33;
	localparam int REM_W  = 35;
	localparam int ROOT_W = 17;

	// Six components per cell: NW x, y, z then SE x, y, z.
	localparam int NUM_COMP = 6;

	typedef enum logic [1:0] {
		U_IDLE,
		U_DIV,
		U_SQRT
	} unit_state_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SQUARE,
		S_SUM,
		S_START,
		S_WAIT,
		S_HOLD
	} ctl_state_t;

	// Work handed to one normalization unit.
	typedef struct packed {
		logic              start;
		logic              neg;
		logic [SQ_W-1:0]   sq;
		logic [SUM_W-1:0]  sumsq;
	} unit_req_t;

endpackage

`default_nettype wire

FILE: rtl/hmtn_unit.sv
// Iterative unit that turns one component and a squared length into a Q1.15 value.
`default_nettype none

module hmtn_unit import hmtn_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire unit_req_t req,
	output logic           done,
	output logic [15:0]    value
);

	unit_state_t state_q, state_d;
	logic [5:0]        cnt_q;
	logic              done_q;
	logic [REM_W-1:0]  rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [ROOT_W-1:0] root_q;
	logic [SUM_W-1:0]  sumsq_q;
	logic              neg_q;

	logic              div_bit;
	logic [REM_W-1:0]  rem_sub;
	logic [ROOT_W-1:0] trial;
	logic [2*ROOT_W-1:0] trial_sq;
	logic              fits;
	logic [ROOT_W:0]   rnd_full;
	logic [ROOT_W-1:0] rnd;
	logic [ROOT_W-1:0] rnd_neg;

	// One restoring division step: quotient of sq * 2^32 by the squared length.
	assign div_bit = rem_q >= {1'b0, sumsq_q};
	assign rem_sub = div_bit ? rem_q - {1'b0, sumsq_q} : rem_q;

	// One square root step, most significant bit first.
	assign trial    = root_q | (ROOT_W'(1) << cnt_q[4:0]);
	assign trial_sq = {{ROOT_W{1'b0}}, trial} * {{ROOT_W{1'b0}}, trial};
	assign fits     = trial_sq <= {1'b0, quo_q};

	// The root is the largest k with k*k no greater than the quotient; (root + 1) / 2 halves it with rounding.
	assign rnd_full = {1'b0, root_q} + (ROOT_W+1)'(1);
	assign rnd      = rnd_full[ROOT_W:1];
	assign rnd_neg  = ROOT_W'(0) - rnd;

	always_comb begin
		if (neg_q) begin
			value = rnd_neg[15:0];
		end else if (rnd > ROOT_W'(32767)) begin
			value = 16'h7FFF;
		end else begin
			value = rnd[15:0];
		end
	end

	assign done = done_q;

	// Sequencer: division steps, then square root steps.
	always_comb begin
		state_d = state_q;
		case (state_q)
			U_IDLE: begin
				if (req.start) state_d = U_DIV;
			end
			U_DIV: begin
				if (cnt_q == 6'(QUO_W-1)) state_d = U_SQRT;
			end
			U_SQRT: begin
				if (cnt_q == 6'd0) state_d = U_IDLE;
			end
			default: state_d = U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			cnt_q   <= 6'd0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == U_IDLE && req.start) begin
				cnt_q  <= 6'd0;
				done_q <= 1'b0;
			end else if (state_q == U_DIV) begin
				cnt_q <= (cnt_q == 6'(QUO_W-1)) ? 6'(ROOT_W-1) : cnt_q + 6'd1;
			end else if (state_q == U_SQRT) begin
				if (cnt_q == 6'd0) begin
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == U_IDLE && req.start) begin
			rem_q   <= {{(REM_W-SQ_W){1'b0}}, req.sq};
			sumsq_q <= req.sumsq;
			neg_q   <= req.neg;
			quo_q   <= '0;
		end else if (state_q == U_DIV) begin
			rem_q <= {rem_sub[REM_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], div_bit};
			if (cnt_q == 6'(QUO_W-1)) root_q <= '0;
		end else if (state_q == U_SQRT) begin
			if (fits) root_q <= trial;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/heightmap_triangle_normals.sv
// Top level of the heightmap triangle normal generator.
`default_nettype none

// Heights enter in raster order, x fastest, one beat per accepted sample. A
// one-line row store (a synchronous memory of MAX_WIDTH entries) holds the
// previous row; once the sample at (x+1,y+1) arrives, the two unit normals of
// cell (x,y) leave as one result beat. A sample that completes no cell (first
// row, first column, or beyond a shrunken size) only goes through the memory
// read and write-back. A sample that completes a cell goes through a memory
// read, squaring and summing, then six parallel normalization units, each
// running 33 division steps and 17 square root steps, one step a cycle. The
// next sample is taken while a finished result still waits at the output.
module heightmap_triangle_normals import hmtn_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int MAX_ROWS  = MAX_ROWS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  wire logic              sample_valid,
	output logic                   sample_stall,
	input  wire logic [15:0]       height_sample,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic [11:0]            cell_col,
	output logic [11:0]            cell_row,
	output logic signed [15:0]     nw_nx,
	output logic signed [15:0]     nw_ny,
	output logic [14:0]            nw_nz,
	output logic signed [15:0]     se_nx,
	output logic signed [15:0]     se_ny,
	output logic [14:0]            se_nz,
	output logic                   frame_done
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_ROWS);

	function automatic logic [15:0] abs17(input logic [16:0] v);
		logic [16:0] n;
		n = 17'd0 - v;
		return v[16] ? n[15:0] : v[15:0];
	endfunction

	// Configuration registers.
	logic [12:0] grid_width_q;
	logic [12:0] grid_height_q;
	logic [15:0] cell_spacing_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q   <= 13'd4096;
			grid_height_q  <= 13'd4096;
			cell_spacing_q <= 16'd1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_GRID_WIDTH:   grid_width_q   <= pwdata[12:0];
				REG_GRID_HEIGHT:  grid_height_q  <= pwdata[12:0];
				REG_CELL_SPACING: cell_spacing_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_GRID_WIDTH:   prdata = {19'd0, grid_width_q};
			REG_GRID_HEIGHT:  prdata = {19'd0, grid_height_q};
			REG_CELL_SPACING: prdata = {16'd0, cell_spacing_q};
			default:          prdata = 32'd0;
		endcase
	end

	// Effective frame size, clamped into the supported range.
	logic [31:0] w32, h32;
	logic [CW:0] w_eff;
	logic [RW:0] h_eff;

	always_comb begin
		if (32'(grid_width_q) < 32'd2) w32 = 32'd2;
		else if (32'(grid_width_q) > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
		else w32 = 32'(grid_width_q);
		if (32'(grid_height_q) < 32'd2) h32 = 32'd2;
		else if (32'(grid_height_q) > 32'(MAX_ROWS)) h32 = 32'(MAX_ROWS);
		else h32 = 32'(grid_height_q);
	end

	assign w_eff = w32[CW:0];
	assign h_eff = h32[RW:0];

	// Control state.
	ctl_state_t state_q, state_d;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [15:0]   left_q;
	logic [15:0]   upleft_q;
	logic          out_valid_q;
	logic          accept;
	logic          out_free;
	logic          emit;
	logic          all_done;

	assign sample_stall = state_q != S_IDLE;
	assign accept       = sample_valid && !sample_stall;
	assign out_free     = !out_valid_q || !result_stall;

	// Row store: read at accept, written back in the following cycle.
	logic [15:0] row_mem [MAX_WIDTH];
	logic [15:0] rd_q;
	logic [15:0] h_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= row_mem[col_q];
			h_s1 <= height_sample;
		end
		if (state_q == S_READ) row_mem[col_q] <= h_s1;
	end

	// Cell test and counter advance.
	logic [CW:0]  col_inc;
	logic [RW:0]  row_inc;
	logic [31:0]  col_m1, row_m1;
	logic         last_cell;

	assign emit = (col_q != '0) && ({1'b0, col_q} < w_eff)
		&& (row_q != '0) && ({1'b0, row_q} < h_eff);
	assign col_inc   = {1'b0, col_q} + (CW+1)'(1);
	assign row_inc   = {1'b0, row_q} + (RW+1)'(1);
	assign col_m1    = 32'(col_q) - 32'd1;
	assign row_m1    = 32'(row_q) - 32'd1;
	assign last_cell = ({1'b0, col_q} == w_eff - (CW+1)'(1))
		&& ({1'b0, row_q} == h_eff - (RW+1)'(1));

	// Sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (accept) state_d = S_READ;
			S_READ:   state_d = emit ? S_SQUARE : S_IDLE;
			S_SQUARE: state_d = S_SUM;
			S_SUM:    state_d = S_START;
			S_START:  state_d = S_WAIT;
			S_WAIT:   if (all_done) state_d = S_HOLD;
			S_HOLD:   if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			left_q      <= 16'd0;
			upleft_q    <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_READ) begin
				upleft_q <= rd_q;
				left_q   <= h_s1;
				if (col_inc >= w_eff) begin
					col_q <= '0;
					row_q <= (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
				end else begin
					col_q <= col_inc[CW-1:0];
					if ({1'b0, row_q} >= h_eff) row_q <= '0;
				end
			end
			if (state_q == S_HOLD && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Component differences, taken as magnitude and sign.
	logic [16:0] ax, ay, bx, by;
	logic [15:0] s_eff;
	logic [15:0] mag_s2 [NUM_COMP];
	logic        neg_s2 [NUM_COMP];
	logic [11:0] cell_col_s2, cell_row_s2;
	logic        last_s2;

	assign ax    = {1'b0, left_q} - {1'b0, h_s1};
	assign ay    = {1'b0, left_q} - {1'b0, upleft_q};
	assign bx    = {1'b0, upleft_q} - {1'b0, rd_q};
	assign by    = {1'b0, h_s1} - {1'b0, rd_q};
	assign s_eff = (cell_spacing_q == 16'd0) ? 16'd1 : cell_spacing_q;

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			mag_s2[0] <= abs17(ax);
			neg_s2[0] <= ax[16];
			mag_s2[1] <= abs17(ay);
			neg_s2[1] <= ay[16];
			mag_s2[2] <= s_eff;
			neg_s2[2] <= 1'b0;
			mag_s2[3] <= abs17(bx);
			neg_s2[3] <= bx[16];
			mag_s2[4] <= abs17(by);
			neg_s2[4] <= by[16];
			mag_s2[5] <= s_eff;
			neg_s2[5] <= 1'b0;
			cell_col_s2 <= col_m1[11:0];
			cell_row_s2 <= row_m1[11:0];
			last_s2     <= last_cell;
		end
	end

	// Squares, then the two squared lengths.
	logic [SQ_W-1:0]  sq_s3 [NUM_COMP];
	logic [SUM_W-1:0] la_s4, lb_s4;

	always_ff @(posedge clk) begin
		if (state_q == S_SQUARE) begin
			for (int i = 0; i < NUM_COMP; i++) begin
				sq_s3[i] <= {16'd0, mag_s2[i]} * {16'd0, mag_s2[i]};
			end
		end
		if (state_q == S_SUM) begin
			la_s4 <= SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);
			lb_s4 <= SUM_W'(sq_s3[3]) + SUM_W'(sq_s3[4]) + SUM_W'(sq_s3[5]);
		end
	end

	// Six normalization units, one per component.
	unit_req_t   req [NUM_COMP];
	logic        udone [NUM_COMP];
	logic [15:0] uval [NUM_COMP];

	for (genvar g = 0; g < NUM_COMP; g++) begin : g_unit
		assign req[g].start = state_q == S_START;
		assign req[g].neg   = neg_s2[g];
		assign req[g].sq    = sq_s3[g];
		assign req[g].sumsq = (g < NUM_COMP/2) ? la_s4 : lb_s4;

		hmtn_unit u_unit (
			.clk    (clk),
			.arst_n (arst_n),
			.req    (req[g]),
			.done   (udone[g]),
			.value  (uval[g])
		);
	end

	always_comb begin
		all_done = 1'b1;
		for (int i = 0; i < NUM_COMP; i++) begin
			all_done = all_done && udone[i];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (state_q == S_HOLD && out_free) begin
			cell_col   <= cell_col_s2;
			cell_row   <= cell_row_s2;
			nw_nx      <= uval[0];
			nw_ny      <= uval[1];
			nw_nz      <= uval[2][14:0];
			se_nx      <= uval[3];
			se_ny      <= uval[4];
			se_nz      <= uval[5][14:0];
			frame_done <= last_s2;
		end
	end

	assign result_valid = out_valid_q;

endmodule

`default_nettype wire
